@@ rtl/mcia_pkg.sv @@
// Shared types and constants for the multicore interrupt/alarm controller.
// No dependencies; used by mcia_lane and the controller core.
package mcia_pkg;

   // Number of cores served (1 to 4).
   localparam int NUM_CORES = 3;

   // Width of the per-core alarm-fired field in the result word.
   localparam int FIRED_W = 3;

   localparam logic [63:0] NEVER_TIME = 64'hFFFF_FFFF_FFFF_FFFF;

   // Request codes
   localparam logic [2:0] REQ_POST      = 3'd0;
   localparam logic [2:0] REQ_CLEAR     = 3'd1;
   localparam logic [2:0] REQ_SET_MASK  = 3'd2;
   localparam logic [2:0] REQ_CHECK     = 3'd3;
   localparam logic [2:0] REQ_SET_ALARM = 3'd4;
   localparam logic [2:0] REQ_TICK      = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_NONMASKABLE = 2'd0;
   localparam logic [1:0] CSR_ALARM_FLAG  = 2'd1;
   localparam logic [1:0] CSR_DEBUG_BREAK = 2'd2;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [1:0]  core_index;
      logic [31:0] flags;
      logic [31:0] new_mask;
      logic        breakpoint_hit;
      logic [63:0] wake_time;
      logic [63:0] current_time;
   } req_word_type;

   typedef struct packed {
      logic [31:0]        mask_out;
      logic               deliver;
      logic [31:0]        delivered_flags;
      logic [FIRED_W-1:0] alarms_fired;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] nonmaskable_bits;
      logic [31:0] alarm_flag_bits;
      logic [31:0] debug_break_bits;
   } cfg_type;

   // One-hot operation strobes for one core, already qualified by the
   // pipeline advance.
   typedef struct packed {
      logic        tick;
      logic        post;
      logic        clear;
      logic        set_mask;
      logic        check;
      logic        set_alarm;
      logic        debug_post;
      logic [31:0] flags;
      logic [31:0] new_mask;
      logic [63:0] wake_time;
      logic [63:0] current_time;
   } lane_cmd_type;

   typedef struct packed {
      logic [31:0] mask;
      logic [31:0] pending;
      logic        fired;
   } lane_stat_type;

endpackage

@@ rtl/mcia_lane.sv @@
// State of one core: pending flags, enable mask and alarm deadline.
// Depends on mcia_pkg for the command, status and configuration types.
module mcia_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  mcia_pkg::cfg_type     cfg,
   input  mcia_pkg::lane_cmd_type cmd,
   output mcia_pkg::lane_stat_type stat
);
   import mcia_pkg::*;

   logic [31:0] pending_ff, pending_in;
   logic [31:0] mask_ff, mask_in;
   logic [63:0] deadline_ff, deadline_in;
   logic        due;

   assign due = (deadline_ff != NEVER_TIME) && (deadline_ff <= cmd.current_time);

   always_comb begin
      pending_in  = pending_ff;
      mask_in     = mask_ff;
      deadline_in = deadline_ff;
      if (cmd.tick && due) begin
         // disarm and raise the alarm flags
         deadline_in = NEVER_TIME;
         pending_in  = pending_ff | cfg.alarm_flag_bits;
      end
      if (cmd.post) begin
         pending_in = pending_ff | cmd.flags;
      end
      if (cmd.clear) begin
         pending_in = pending_ff & ~cmd.flags;
      end
      if (cmd.set_mask) begin
         mask_in = cmd.new_mask;
      end
      if (cmd.check) begin
         // drop every enabled bit
         pending_in = pending_ff & ~(mask_ff | cfg.nonmaskable_bits);
      end
      if (cmd.debug_post) begin
         pending_in = pending_ff | cfg.debug_break_bits;
      end
      if (cmd.set_alarm) begin
         deadline_in = cmd.wake_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         mask_ff     <= '0;
         deadline_ff <= NEVER_TIME;
      end else begin
         pending_ff  <= pending_in;
         mask_ff     <= mask_in;
         deadline_ff <= deadline_in;
      end
   end

   assign stat.mask    = mask_ff;
   assign stat.pending = pending_ff;
   assign stat.fired   = cmd.tick && due;

endmodule

@@ rtl/multicore_interrupt_alarm_controller_core.sv @@
// Multicore interrupt/alarm controller: per-core pending flags, masks, alarms.
// Depends on mcia_pkg and mcia_lane. A request is held in the input register,
// then its result word in the result register. Throughput: one request word per
// cycle while the result is not stalled; the per-core state update and result
// are computed in a single pass from the input register.
// Synchronous reset clears masks and flags, disarms all alarms.
module multicore_interrupt_alarm_controller_core (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mcia_pkg::req_word_type req_word,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mcia_pkg::rsp_word_type rsp_word,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);
   import mcia_pkg::*;

   // ---------------------------------------------------------------
   // Config registers, always ready; user writes only while idle, not enforced.
   // ---------------------------------------------------------------
   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NONMASKABLE: cfg_in.nonmaskable_bits = csr_data;
            CSR_ALARM_FLAG:  cfg_in.alarm_flag_bits  = csr_data;
            CSR_DEBUG_BREAK: cfg_in.debug_break_bits = csr_data;
            default:         cfg_in = cfg_ff;  // unmapped index: drop
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nonmaskable_bits <= 32'h0000_0000;
         cfg_ff.alarm_flag_bits  <= 32'h0000_0001;
         cfg_ff.debug_break_bits <= 32'h0000_0002;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------
   // Input register. It refills in the same cycle it hands its word
   // on, so a stalled result only backs up once both stages are full.
   // ---------------------------------------------------------------
   req_word_type in_word_ff;
   logic         in_valid_ff, in_valid_in;
   logic         advance;
   logic         req_accept;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // The compute stage moves when it holds a word and the result slot is
   // empty or being emptied this cycle.
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff <= req_word;
      end
   end

   // ---------------------------------------------------------------
   // Decode the held request.
   // ---------------------------------------------------------------
   logic core_ok;
   logic is_post, is_clear, is_set_mask, is_check, is_set_alarm, is_tick;

   assign core_ok = int'(in_word_ff.core_index) < NUM_CORES;

   always_comb begin
      is_post      = 1'b0;
      is_clear     = 1'b0;
      is_set_mask  = 1'b0;
      is_check     = 1'b0;
      is_set_alarm = 1'b0;
      is_tick      = 1'b0;
      case (in_word_ff.req_type)
         REQ_POST:      is_post      = 1'b1;
         REQ_CLEAR:     is_clear     = 1'b1;
         REQ_SET_MASK:  is_set_mask  = 1'b1;
         REQ_CHECK:     is_check     = 1'b1;
         REQ_SET_ALARM: is_set_alarm = 1'b1;
         REQ_TICK:      is_tick      = 1'b1;
         default:       ;  // unknown request: touch nothing
      endcase
   end

   // ---------------------------------------------------------------
   // Per-core state. Each lane gets strobes only on an advancing word;
   // a breakpoint check posts the debug bits to every other core.
   // ---------------------------------------------------------------
   lane_cmd_type  lane_cmd  [NUM_CORES];
   lane_stat_type lane_stat [NUM_CORES];
   logic [NUM_CORES-1:0] lane_sel;
   logic [NUM_CORES-1:0] lane_fired;

   for (genvar gi = 0; gi < NUM_CORES; gi++) begin : g_lane
      logic own;
      logic other;

      assign lane_sel[gi] = core_ok && (int'(in_word_ff.core_index) == gi);
      assign own   = advance && lane_sel[gi];
      assign other = advance && core_ok && !lane_sel[gi];

      assign lane_cmd[gi].tick         = advance && is_tick;
      assign lane_cmd[gi].post         = own && is_post;
      assign lane_cmd[gi].clear        = own && is_clear;
      assign lane_cmd[gi].set_mask     = own && is_set_mask;
      assign lane_cmd[gi].check        = own && is_check;
      assign lane_cmd[gi].set_alarm    = own && is_set_alarm;
      assign lane_cmd[gi].debug_post   = other && is_check && in_word_ff.breakpoint_hit;
      assign lane_cmd[gi].flags        = in_word_ff.flags;
      assign lane_cmd[gi].new_mask     = in_word_ff.new_mask;
      assign lane_cmd[gi].wake_time    = in_word_ff.wake_time;
      assign lane_cmd[gi].current_time = in_word_ff.current_time;

      mcia_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cfg   (cfg_ff),
         .cmd   (lane_cmd[gi]),
         .stat  (lane_stat[gi])
      );

      assign lane_fired[gi] = lane_stat[gi].fired;
   end

   // ---------------------------------------------------------------
   // Result: select the addressed core's mask and flags (zero when the
   // core number is out of range), then evaluate the check.
   // ---------------------------------------------------------------
   logic [31:0] sel_mask;
   logic [31:0] sel_pending;
   logic [31:0] enabled;
   logic [31:0] taken;
   logic        hit;

   always_comb begin
      sel_mask    = '0;
      sel_pending = '0;
      for (int i = 0; i < NUM_CORES; i++) begin
         if (lane_sel[i]) begin
            sel_mask    = sel_mask | lane_stat[i].mask;
            sel_pending = sel_pending | lane_stat[i].pending;
         end
      end
   end

   assign enabled = sel_mask | cfg_ff.nonmaskable_bits;
   assign taken   = sel_pending |
                    (in_word_ff.breakpoint_hit ? cfg_ff.debug_break_bits : 32'h0);
   assign hit     = is_check && core_ok && ((taken & enabled) != 32'h0);

   always_comb begin
      rsp_word_in.mask_out        = sel_mask;
      rsp_word_in.deliver         = hit;
      rsp_word_in.delivered_flags = hit ? taken : 32'h0;
      // only the first FIRED_W cores are reported
      rsp_word_in.alarms_fired    = FIRED_W'(lane_fired);
   end

   // ---------------------------------------------------------------
   // Result register: load on advance, hold while stalled.
   // ---------------------------------------------------------------
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_fire_only_on_tick : assert property (@(posedge clock) disable iff (reset)
      (advance && (lane_fired != '0)) |-> is_tick)
      else $error("alarm fired outside a tick");

   a_deliver_has_flags : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.deliver) |-> (rsp_word_ff.delivered_flags != 32'h0))
      else $error("delivered with empty flags");

   a_no_word_lost : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |=> (in_valid_ff && rsp_valid_ff))
      else $error("held word dropped under stall");

   a_drain : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !in_valid_ff) |=> !rsp_valid_ff)
      else $error("result repeated after it was taken");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
